FILE: sv/h2u8_pkg.sv
// ----------------------------------------------------------------------------
// h2u8_pkg
// Shared types, constants and helpers for the hex code point to UTF-8 unit.
// ----------------------------------------------------------------------------
package h2u8_pkg;

  localparam int unsigned MAX_HEX_DIGITS = 6;
  localparam int unsigned CNT_W          = 3;
  localparam int unsigned VAL_W          = 24;

  typedef logic [7:0]       byte_t;
  typedef logic [VAL_W-1:0] code_t;

  // prefix tracking codes
  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_U     = 2'd1;
  localparam logic [1:0] PH_BODY  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOHEX = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam byte_t CH_U    = 8'h55;
  localparam byte_t CH_PLUS = 8'h2B;

  localparam code_t LIM_1B  = 24'h000080;
  localparam code_t LIM_2B  = 24'h000800;
  localparam code_t LIM_3B  = 24'h010000;
  localparam code_t LIM_MAX = 24'h110000;

  localparam byte_t LEAD_2B = 8'hC0;
  localparam byte_t LEAD_3B = 8'hE0;
  localparam byte_t LEAD_4B = 8'hF0;
  localparam byte_t CONT_B  = 8'h80;

  // encoded code point: up to four bytes, first byte in slot 0
  typedef struct packed {
    byte_t [3:0] bytes;
    logic  [2:0] count;
    logic  [1:0] status;
  } enc_t;

  // {is_hex, digit value}
  function automatic logic [4:0] hex_value(input byte_t c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

FILE: sv/h2u8_if.sv
// ----------------------------------------------------------------------------
// h2u8 stream interfaces
// Character input channel and encoded byte output channel.
// ----------------------------------------------------------------------------
interface h2u8_in_if import h2u8_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t char_in;
  logic  end_of_string;
  logic  no_char;

  modport source (output valid, char_in, end_of_string, no_char, input ready);
  modport sink   (input valid, char_in, end_of_string, no_char, output ready);
endinterface

interface h2u8_out_if import h2u8_pkg::*; ();
  logic       valid;
  logic       ready;
  byte_t      utf8_byte;
  logic       run_last;
  logic [1:0] status;

  modport source (output valid, utf8_byte, run_last, status, input ready);
  modport sink   (input valid, utf8_byte, run_last, status, output ready);
endinterface

FILE: sv/h2u8_encode.sv
// ----------------------------------------------------------------------------
// h2u8_encode
// Range check and UTF-8 byte split of one gathered code point.
// ----------------------------------------------------------------------------
module h2u8_encode import h2u8_pkg::*; (
  input  code_t value_i,
  input  logic  bad_i,
  output enc_t  enc_o
);

  always_comb begin
    enc_o        = '0;
    enc_o.count  = 3'd1;
    enc_o.status = ST_OK;
    if (bad_i) begin
      enc_o.status = ST_NOHEX;
    end else if (value_i >= LIM_MAX) begin
      enc_o.status = ST_RANGE;
    end else if (value_i < LIM_1B) begin
      enc_o.bytes[0] = value_i[7:0];
    end else if (value_i < LIM_2B) begin
      enc_o.count    = 3'd2;
      enc_o.bytes[0] = LEAD_2B | {3'b000, value_i[10:6]};
      enc_o.bytes[1] = CONT_B | {2'b00, value_i[5:0]};
    end else if (value_i < LIM_3B) begin
      enc_o.count    = 3'd3;
      enc_o.bytes[0] = LEAD_3B | {4'b0000, value_i[15:12]};
      enc_o.bytes[1] = CONT_B | {2'b00, value_i[11:6]};
      enc_o.bytes[2] = CONT_B | {2'b00, value_i[5:0]};
    end else begin
      enc_o.count    = 3'd4;
      enc_o.bytes[0] = LEAD_4B | {5'b00000, value_i[20:18]};
      enc_o.bytes[1] = CONT_B | {2'b00, value_i[17:12]};
      enc_o.bytes[2] = CONT_B | {2'b00, value_i[11:6]};
      enc_o.bytes[3] = CONT_B | {2'b00, value_i[5:0]};
    end
  end

endmodule

FILE: sv/hex_codepoint_to_utf8_unit.sv
// ----------------------------------------------------------------------------
// hex_codepoint_to_utf8_unit
// Parses a hex code point string (optional "U+") and emits its UTF-8 bytes.
// ----------------------------------------------------------------------------
// Characters are taken one per cycle into an input register (unless a closing
// character is held there) and parsed from there; characters that do not close a
// string give no output. The closing character loads the encoded bytes (one to
// four, or a single error beat) into a byte buffer that drains one beat per cycle,
// while the output accepts, through the output register, so a closing character
// waits in the input register until the previous code point has at most one beat
// left and that beat is leaving.
module hex_codepoint_to_utf8_unit import h2u8_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  h2u8_in_if.sink     in_i,
  h2u8_out_if.source  out_o
);

  // input register
  logic  s1_valid_q;
  byte_t s1_char_q;
  logic  s1_eos_q;
  logic  s1_none_q;

  // parser state
  logic [1:0]       phase_q, phase_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  code_t            val_q, val_d;
  logic             bad_q, bad_d;
  logic             bad_fin;
  logic             take;
  logic [4:0]       hv;

  // byte buffer
  byte_t [3:0] buf_q;
  logic  [2:0] rem_q;
  logic  [1:0] bst_q;

  // output register
  logic       out_valid_q;
  byte_t      out_byte_q;
  logic       out_last_q;
  logic [1:0] out_st_q;

  logic out_free, pop, buf_load, consume;
  enc_t enc;

  assign out_free = !out_valid_q || out_o.ready;
  assign pop      = (rem_q != 3'd0) && out_free;
  // a closing item needs the buffer empty after this cycle
  assign consume  = s1_valid_q && (!s1_eos_q || rem_q == 3'd0 ||
                                   (rem_q == 3'd1 && pop));
  assign buf_load = consume && s1_eos_q;
  assign in_i.ready = !s1_valid_q || consume;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    val_d   = val_q;
    bad_d   = bad_q;
    take    = 1'b0;
    hv      = hex_value(s1_char_q);
    if (!s1_none_q) begin
      case (phase_q)
        PH_START: begin
          if (s1_char_q == CH_U) begin
            phase_d = PH_U;
          end else begin
            phase_d = PH_BODY;
            take    = 1'b1;
          end
        end
        PH_U: begin
          phase_d = PH_BODY;
          if (!(s1_char_q == CH_PLUS && !s1_eos_q)) begin
            bad_d = 1'b1;
          end
        end
        default: begin
          take = 1'b1;
        end
      endcase
    end
    if (take && !bad_q && cnt_q < CNT_W'(MAX_HEX_DIGITS)) begin
      if (hv[4]) begin
        val_d = {val_q[VAL_W-5:0], hv[3:0]};
        cnt_d = cnt_q + CNT_W'(1);
      end else begin
        bad_d = 1'b1;
      end
    end
    // a lone leading U is a non-hex character
    bad_fin = bad_d || (phase_d == PH_U);
  end

  h2u8_encode u_encode (
    .value_i (val_d),
    .bad_i   (bad_fin),
    .enc_o   (enc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_char_q <= in_i.char_in;
      s1_eos_q  <= in_i.end_of_string;
      s1_none_q <= in_i.no_char;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      cnt_q   <= '0;
      val_q   <= '0;
      bad_q   <= 1'b0;
    end else if (consume) begin
      if (s1_eos_q) begin
        phase_q <= PH_START;
        cnt_q   <= '0;
        val_q   <= '0;
        bad_q   <= 1'b0;
      end else begin
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
        val_q   <= val_d;
        bad_q   <= bad_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 3'd0;
    end else if (buf_load) begin
      rem_q <= enc.count;
    end else if (pop) begin
      rem_q <= rem_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (buf_load) begin
      buf_q <= enc.bytes;
      bst_q <= enc.status;
    end else if (pop) begin
      buf_q <= {8'h00, buf_q[3:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= pop;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_byte_q <= buf_q[0];
      out_last_q <= (rem_q == 3'd1);
      out_st_q   <= bst_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.utf8_byte = out_byte_q;
  assign out_o.run_last  = out_last_q;
  assign out_o.status    = out_st_q;

endmodule
